@@ rtl/core/skt_pkg.sv @@
`default_nettype none

package skt_pkg;

  // Field widths
  localparam int unsigned InW   = 24;         // Q3.20 tangent coordinate
  localparam int unsigned BaseW = 22;         // Q2.20 baseline
  localparam int unsigned OutW  = 32;         // Q15.16 position

  // Divider geometry: all three quotients share the disparity magnitude as divisor
  localparam int unsigned DenW   = InW + 1;   // |left_x - right_x| up to 2^24 - 1
  localparam int unsigned RemW   = DenW - 1;  // remainder stays below the divisor
  localparam int unsigned NumW   = 42;        // pre-scaled dividend
  localparam int unsigned QuoW   = OutW;      // quotient bits before saturation
  localparam int unsigned NumDiv = 3;

  // Lane order inside the divider
  localparam int unsigned IdxX = 0;
  localparam int unsigned IdxY = 1;
  localparam int unsigned IdxZ = 2;

  // Dividend scaling. Rounding offset and the power-of-two part of the divisor
  // are folded into the dividend so that every lane divides by |d| alone.
  localparam int unsigned ZShift = 17;        // 2 * 2^16 for z
  localparam int unsigned XBias  = 3;         // 8 * |d| rounding term for x
  localparam int unsigned XShift = 4;         // divide by 16 for x
  localparam int unsigned YBias  = 4;         // 16 * |d| rounding term for y
  localparam int unsigned YShift = 5;         // divide by 32 for y

  localparam logic [BaseW-1:0] BaseReset = BaseW'(67109);

  localparam logic [OutW-1:0] SatPos = {1'b0, {(OutW - 1){1'b1}}};
  localparam logic [OutW-1:0] SatNeg = {1'b1, {(OutW - 1){1'b0}}};

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusZeroDisp = 2'd1,
    StatusSat      = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [InW-1:0] left_x;
    logic signed [InW-1:0] left_y;
    logic signed [InW-1:0] right_x;
    logic signed [InW-1:0] right_y;
  } in_t;

  typedef struct packed {
    logic signed [OutW-1:0] pos_x;
    logic signed [OutW-1:0] pos_y;
    logic signed [OutW-1:0] pos_z;
    status_e                status;
  } out_t;

  // Sideband that rides along with the divider
  typedef struct packed {
    logic [NumDiv-1:0] neg;
    logic              zero_disp;
  } side_t;

  typedef struct packed {
    logic [NumDiv-1:0][NumW-1:0] num;
    logic [DenW-1:0]             den;
    side_t                       side;
  } div_req_t;

  typedef struct packed {
    logic [NumDiv-1:0][QuoW-1:0] quo;
    logic [NumDiv-1:0]           ov;
    side_t                       side;
  } div_res_t;

endpackage

`default_nettype wire

@@ rtl/core/stereo_keypoint_triangulation_top.sv @@
`default_nettype none

// Stereo keypoint triangulation. Each transfer on the input channel carries one
// matched keypoint as rectified tangent coordinates (Q3.20) from the left and
// right views; each transfer on the output channel returns its position in
// Q15.16: pos_z = -B/d, pos_x = B*(left_x + right_x + d)/(2d) and
// pos_y = -B*(left_y + right_y)/(2d), with d = left_x - right_x and B the
// Q2.20 baseline register (reset about 0.064 m). Every output is rounded once
// to nearest, ties away from zero. A zero disparity returns zero positions with
// status 1; any value outside the Q15.16 range saturates and returns status 2.
// Write the baseline only while no keypoint is in flight. The block takes one
// keypoint per cycle while the skid buffer is empty and passes it through:
// three front stages (disparity and magnitudes, baseline products, dividend
// scaling), one overflow check, 32 restoring-division stages that yield one
// quotient bit each for all three outputs at once, and the output register.
// An output register plus a one-entry skid buffer part the two channels, so
// the input keeps flowing while a result waits; input ready drops only once
// both hold a result.
module stereo_keypoint_triangulation_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [skt_pkg::BaseW-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  skt_pkg::in_t               in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output skt_pkg::out_t              out_data_o
);

  localparam int unsigned PxW  = skt_pkg::BaseW + skt_pkg::InW;
  localparam int unsigned PyW  = skt_pkg::BaseW + skt_pkg::DenW;
  localparam int unsigned SumZW = skt_pkg::BaseW + skt_pkg::ZShift + 1;

  typedef struct packed {
    logic [skt_pkg::DenW-1:0] dmag;
    logic [skt_pkg::InW-1:0]  lxmag;
    logic [skt_pkg::DenW-1:0] smag;
    skt_pkg::side_t           side;
  } a_t;

  typedef struct packed {
    logic [PxW-1:0]           px;
    logic [PyW-1:0]           py;
    logic [skt_pkg::DenW-1:0] dmag;
    skt_pkg::side_t           side;
  } b_t;

  logic [skt_pkg::BaseW-1:0] baseline_q;

  logic adv;
  logic a_vld_q, b_vld_q, c_vld_q;
  a_t   a_d, a_q;
  b_t   b_d, b_q;
  skt_pkg::div_req_t c_d, c_q;

  logic [skt_pkg::InW-1:0]  lx, ly, rx, ry;
  logic [skt_pkg::DenW-1:0] disp, ysum;

  logic [SumZW-1:0] sum_z;
  logic [PxW:0]     sum_x;
  logic [PyW:0]     sum_y;

  logic              res_vld;
  skt_pkg::div_res_t div_res;

  logic [skt_pkg::NumDiv-1:0]                    sat;
  logic [skt_pkg::NumDiv-1:0][skt_pkg::OutW-1:0] val;
  skt_pkg::out_t res_out;

  logic          out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  logic          pop, push, load_out, load_skid, out_from_skid;
  skt_pkg::out_t out_q, skid_q;

  // Baseline register; the user must write it only while the pipeline is empty, which the block itself does not enforce
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q <= skt_pkg::BaseReset;
    end else if (cfg_we_i) begin
      baseline_q <= cfg_wdata_i;
    end
  end

  // The whole pipeline advances unless the skid buffer already holds a result
  assign adv        = ~skid_vld_q;
  assign in_ready_o = adv;

  // Stage A: disparity, y coordinate sum, magnitudes, result signs and zero-disparity flag
  always_comb begin
    lx   = in_data_i.left_x;
    ly   = in_data_i.left_y;
    rx   = in_data_i.right_x;
    ry   = in_data_i.right_y;
    disp = {lx[skt_pkg::InW-1], lx} - {rx[skt_pkg::InW-1], rx};
    ysum = {ly[skt_pkg::InW-1], ly} + {ry[skt_pkg::InW-1], ry};

    a_d.dmag  = disp[skt_pkg::DenW-1] ? ('0 - disp) : disp;
    a_d.lxmag = lx[skt_pkg::InW-1] ? ('0 - lx) : lx;
    a_d.smag  = ysum[skt_pkg::DenW-1] ? ('0 - ysum) : ysum;

    // Sign of each quotient; a zero dividend yields zero whatever the sign
    a_d.side.neg[skt_pkg::IdxX] = lx[skt_pkg::InW-1] ^ disp[skt_pkg::DenW-1];
    a_d.side.neg[skt_pkg::IdxY] = ~ysum[skt_pkg::DenW-1] ^ disp[skt_pkg::DenW-1];
    a_d.side.neg[skt_pkg::IdxZ] = ~disp[skt_pkg::DenW-1];
    a_d.side.zero_disp          = (disp == '0);
  end

  // Stage B: baseline products
  always_comb begin
    b_d.px   = PxW'(baseline_q) * PxW'(a_q.lxmag);
    b_d.py   = PyW'(baseline_q) * PyW'(a_q.smag);
    b_d.dmag = a_q.dmag;
    b_d.side = a_q.side;
  end

  // Stage C: fold the rounding half and the power-of-two divisor into each dividend
  always_comb begin
    sum_z = {1'b0, baseline_q, {skt_pkg::ZShift{1'b0}}} + SumZW'(b_q.dmag);
    sum_x = {1'b0, b_q.px} + ((PxW + 1)'(b_q.dmag) << skt_pkg::XBias);
    sum_y = {1'b0, b_q.py} + ((PyW + 1)'(b_q.dmag) << skt_pkg::YBias);

    c_d.num[skt_pkg::IdxZ] = skt_pkg::NumW'(sum_z[SumZW-1:1]);
    c_d.num[skt_pkg::IdxX] = sum_x[skt_pkg::XShift +: skt_pkg::NumW];
    c_d.num[skt_pkg::IdxY] = sum_y[skt_pkg::YShift +: skt_pkg::NumW];
    c_d.den                = b_q.dmag;
    c_d.side               = b_q.side;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= in_valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q <= a_d;
      b_q <= b_d;
      c_q <= c_d;
    end
  end

  skt_div_pipe u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .req_valid_i (c_vld_q),
    .req_i       (c_q),
    .res_valid_o (res_vld),
    .res_o       (div_res)
  );

  // Apply sign, saturate, and override everything on zero disparity
  always_comb begin
    res_out = '0;
    for (int i = 0; i < skt_pkg::NumDiv; i++) begin
      if (div_res.side.neg[i]) begin
        sat[i] = div_res.ov[i] |
                 (div_res.quo[i][skt_pkg::QuoW-1] & (|div_res.quo[i][skt_pkg::QuoW-2:0]));
        val[i] = sat[i] ? skt_pkg::SatNeg : ('0 - div_res.quo[i]);
      end else begin
        sat[i] = div_res.ov[i] | div_res.quo[i][skt_pkg::QuoW-1];
        val[i] = sat[i] ? skt_pkg::SatPos : div_res.quo[i];
      end
    end
    if (div_res.side.zero_disp) begin
      res_out.status = skt_pkg::StatusZeroDisp;
    end else begin
      res_out.pos_x  = val[skt_pkg::IdxX];
      res_out.pos_y  = val[skt_pkg::IdxY];
      res_out.pos_z  = val[skt_pkg::IdxZ];
      res_out.status = (|sat) ? skt_pkg::StatusSat : skt_pkg::StatusOk;
    end
  end

  // Output register with one skid entry behind it
  always_comb begin
    pop           = out_vld_q & out_ready_i;
    push          = adv & res_vld;
    out_vld_d     = out_vld_q;
    skid_vld_d    = skid_vld_q;
    load_out      = 1'b0;
    load_skid     = 1'b0;
    out_from_skid = 1'b0;
    if (skid_vld_q) begin
      if (pop) begin
        out_from_skid = 1'b1;
        skid_vld_d    = 1'b0;
      end
    end else if (push) begin
      if (!out_vld_q || pop) begin
        load_out  = 1'b1;
        out_vld_d = 1'b1;
      end else begin
        load_skid  = 1'b1;
        skid_vld_d = 1'b1;
      end
    end else if (pop) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= res_out;
    end else if (out_from_skid) begin
      out_q <= skid_q;
    end
    if (load_skid) begin
      skid_q <= res_out;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry held without an output result");

  a_skid_fill_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && !out_ready_i))
    else $error("skid entry filled while output was free");

  a_sat_extreme : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_q.status == skt_pkg::StatusSat) |->
      (out_q.pos_x == skt_pkg::SatPos) || (out_q.pos_x == skt_pkg::SatNeg) ||
      (out_q.pos_y == skt_pkg::SatPos) || (out_q.pos_y == skt_pkg::SatNeg) ||
      (out_q.pos_z == skt_pkg::SatPos) || (out_q.pos_z == skt_pkg::SatNeg))
    else $error("saturation status without a saturated field");
`endif

endmodule

`default_nettype wire

@@ rtl/core/skt_div_pipe.sv @@
`default_nettype none

// Three restoring dividers sharing one divisor, one quotient bit per stage.
module skt_div_pipe (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                req_valid_i,
  input  skt_pkg::div_req_t   req_i,
  output logic                res_valid_o,
  output skt_pkg::div_res_t   res_o
);

  localparam int unsigned Steps = skt_pkg::QuoW;
  localparam int unsigned HiW   = skt_pkg::NumW - skt_pkg::QuoW;

  typedef struct packed {
    logic [skt_pkg::NumDiv-1:0][skt_pkg::RemW-1:0] rem;
    logic [skt_pkg::NumDiv-1:0][skt_pkg::QuoW-1:0] nq;   // dividend bits out, quotient in
    logic [skt_pkg::NumDiv-1:0]                    ov;
    logic [skt_pkg::DenW-1:0]                      den;
    skt_pkg::side_t                                side;
  } stage_t;

  stage_t          st_d [0:Steps];
  stage_t          st_q [0:Steps];
  logic [Steps:0]  vld_q;

  // Entry stage: quotient too wide for QuoW bits when the top dividend bits reach |d|
  always_comb begin
    st_d[0].den  = req_i.den;
    st_d[0].side = req_i.side;
    for (int i = 0; i < skt_pkg::NumDiv; i++) begin
      st_d[0].ov[i]  = {{(skt_pkg::DenW - HiW){1'b0}},
                        req_i.num[i][skt_pkg::NumW-1:skt_pkg::QuoW]} >= req_i.den;
      st_d[0].rem[i] = {{(skt_pkg::RemW - HiW){1'b0}},
                        req_i.num[i][skt_pkg::NumW-1:skt_pkg::QuoW]};
      st_d[0].nq[i]  = req_i.num[i][skt_pkg::QuoW-1:0];
    end
  end

  for (genvar k = 1; k <= Steps; k++) begin : g_step
    logic [skt_pkg::NumDiv-1:0][skt_pkg::DenW-1:0] trial;
    logic [skt_pkg::NumDiv-1:0][skt_pkg::DenW-1:0] diff;
    logic [skt_pkg::NumDiv-1:0]                    ge;

    always_comb begin
      st_d[k] = st_q[k-1];
      for (int i = 0; i < skt_pkg::NumDiv; i++) begin
        trial[i] = {st_q[k-1].rem[i], st_q[k-1].nq[i][skt_pkg::QuoW-1]};
        diff[i]  = trial[i] - st_q[k-1].den;
        ge[i]    = trial[i] >= st_q[k-1].den;
        st_d[k].rem[i] = ge[i] ? diff[i][skt_pkg::RemW-1:0] : trial[i][skt_pkg::RemW-1:0];
        st_d[k].nq[i]  = {st_q[k-1].nq[i][skt_pkg::QuoW-2:0], ge[i]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Steps-1:0], req_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= Steps; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign res_valid_o = vld_q[Steps];
  assign res_o.quo   = st_q[Steps].nq;
  assign res_o.ov    = st_q[Steps].ov;
  assign res_o.side  = st_q[Steps].side;

`ifndef SYNTHESIS
  a_zero_den_ov : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] && (st_q[0].den == '0) |-> (&st_q[0].ov))
    else $error("zero divisor not flagged as overflow");

  a_rem_below_den : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[Steps] |->
      (st_q[Steps].ov[skt_pkg::IdxX] ||
       ({1'b0, st_q[Steps].rem[skt_pkg::IdxX]} < st_q[Steps].den)) &&
      (st_q[Steps].ov[skt_pkg::IdxY] ||
       ({1'b0, st_q[Steps].rem[skt_pkg::IdxY]} < st_q[Steps].den)) &&
      (st_q[Steps].ov[skt_pkg::IdxZ] ||
       ({1'b0, st_q[Steps].rem[skt_pkg::IdxZ]} < st_q[Steps].den)))
    else $error("final remainder not below divisor");

  a_hold_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(vld_q))
    else $error("valid bits moved while stalled");
`endif

endmodule

`default_nettype wire

@@ dv/stereo_keypoint_triangulation_top_tb.sv @@
`timescale 1ns / 1ps

module stereo_keypoint_triangulation_top_tb;

  // Coordinate extremes of a signed Q3.20 field
  localparam logic signed [skt_pkg::InW-1:0] CoordMax = {1'b0, {(skt_pkg::InW - 1){1'b1}}};
  localparam logic signed [skt_pkg::InW-1:0] CoordMin = {1'b1, {(skt_pkg::InW - 1){1'b0}}};
  localparam logic signed [skt_pkg::InW-1:0] CoordOne = {{(skt_pkg::InW - 1){1'b0}}, 1'b1};
  localparam logic signed [skt_pkg::InW-1:0] Corner [5] =
    '{CoordMin, CoordMax, '0, '1, CoordOne};
  localparam logic [skt_pkg::BaseW-1:0] BaseMax = {skt_pkg::BaseW{1'b1}};

  localparam int unsigned ItemsPerPhase = 250;
  // Settling time that lets stray results show up after the final drain
  localparam int unsigned SettleCycles = 50;

  // Predicts the position of every accepted keypoint and holds the
  // predictions in transfer order until the matching result comes back.
  class triangulation_scoreboard;
    logic [skt_pkg::BaseW-1:0] baseline;
    skt_pkg::out_t             expected_positions[$];
    int unsigned               n_points;
    int unsigned               n_zero_disp;
    int unsigned               n_saturated;
    int unsigned               n_errors;

    function new();
      baseline    = skt_pkg::BaseReset;
      n_points    = 0;
      n_zero_disp = 0;
      n_saturated = 0;
      n_errors    = 0;
    endfunction

    function int pending();
      return expected_positions.size();
    endfunction

    // Nearest quotient, ties away from zero, clipped to the Q15.16 range
    function logic [skt_pkg::OutW-1:0] round_div(longint num, longint den,
                                                 output bit clipped);
      longint unsigned n;
      longint unsigned m;
      longint unsigned q;
      n = (num < 0) ? -num : num;
      m = (den < 0) ? -den : den;
      q = (2 * n + m) / (2 * m);
      clipped = 1'b0;
      if ((num < 0) != (den < 0)) begin
        if (q > 64'd2147483648) begin
          clipped = 1'b1;
          q = 64'd2147483648;
        end
        q = -q;
      end else if (q > 64'd2147483647) begin
        clipped = 1'b1;
        q = 64'd2147483647;
      end
      return q[skt_pkg::OutW-1:0];
    endfunction

    function void note_input(skt_pkg::in_t pt);
      longint        lx, ly, rx, ry, b, d;
      bit            cz, cx, cy;
      skt_pkg::out_t want;
      lx = $signed(pt.left_x);
      ly = $signed(pt.left_y);
      rx = $signed(pt.right_x);
      ry = $signed(pt.right_y);
      b  = longint'(baseline);
      d  = lx - rx;
      want = '0;
      n_points++;
      if (d == 0) begin
        want.status = skt_pkg::StatusZeroDisp;
        n_zero_disp++;
      end else begin
        // Scale Q20 over Q20 to Q16; the halving of x and y goes into the divisor
        want.pos_z = round_div(-(b * 65536), d, cz);
        want.pos_x = round_div(b * (lx + rx + d), d * 32, cx);
        want.pos_y = round_div(-(b * (ly + ry)), d * 32, cy);
        if (cz || cx || cy) begin
          want.status = skt_pkg::StatusSat;
          n_saturated++;
        end else begin
          want.status = skt_pkg::StatusOk;
        end
      end
      expected_positions.push_back(want);
    endfunction

    function void compare_field(string name, logic [skt_pkg::OutW-1:0] want,
                                logic [skt_pkg::OutW-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
        n_errors++;
      end
    endfunction

    function void check_result(skt_pkg::out_t got);
      skt_pkg::out_t want;
      if (expected_positions.size() == 0) begin
        $error("result with no keypoint outstanding: pos_x %0d pos_y %0d pos_z %0d status %0d",
               got.pos_x, got.pos_y, got.pos_z, got.status);
        n_errors++;
        return;
      end
      want = expected_positions.pop_front();
      compare_field("pos_x", want.pos_x, got.pos_x);
      compare_field("pos_y", want.pos_y, got.pos_y);
      compare_field("pos_z", want.pos_z, got.pos_z);
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        n_errors++;
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [skt_pkg::BaseW-1:0] cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  skt_pkg::in_t              in_data_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  skt_pkg::out_t             out_data_o;

  // Idling switches for the current phase: sender gaps and receiver stalls
  bit               src_idle;
  bit               sink_idle;
  int unsigned      n_settings;

  triangulation_scoreboard sb;

  stereo_keypoint_triangulation_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic skt_pkg::in_t make_point(longint lx, longint ly, longint rx, longint ry);
    skt_pkg::in_t pt;
    pt.left_x  = lx[skt_pkg::InW-1:0];
    pt.left_y  = ly[skt_pkg::InW-1:0];
    pt.right_x = rx[skt_pkg::InW-1:0];
    pt.right_y = ry[skt_pkg::InW-1:0];
    return pt;
  endfunction

  // Offer one keypoint after a random gap while src_idle is set and hold it until the transfer.
  // Valid is only ever assigned once per falling edge, so back-to-back
  // keypoints keep valid high without a glitch.
  task automatic send_point(input skt_pkg::in_t pt);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 5) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= pt;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(pt);
  endtask

  // Drop valid and hold off until every outstanding position has come back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Only called with nothing in flight; the write lands on the next rising edge
  task automatic write_baseline(input logic [skt_pkg::BaseW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.baseline = value;
    n_settings++;
  endtask

  // One baseline setting with a batch of random keypoints. Most keypoints are
  // shaped: small disparities drive the divider towards saturation, points in
  // a realistic field of view give ordinary depths, and some hit zero
  // disparity or the coordinate corners. The rest are raw random bits.
  task automatic run_phase(input logic [skt_pkg::BaseW-1:0] value, input int unsigned mode);
    logic signed [skt_pkg::InW-1:0] lx, ly, rx, ry;
    longint                         delta;
    longint                         shifted;
    longint                         raw;
    write_baseline(value);
    src_idle  = (mode & 1) != 0;
    sink_idle = (mode & 2) != 0;
    for (int unsigned i = 0; i < ItemsPerPhase; i++) begin
      // Pause the sender mid-phase until the pipeline has emptied
      if (i == ItemsPerPhase / 2) drain();
      raw = longint'($urandom);
      lx  = raw[skt_pkg::InW-1:0];
      raw = longint'($urandom);
      ly  = raw[skt_pkg::InW-1:0];
      raw = longint'($urandom);
      rx  = raw[skt_pkg::InW-1:0];
      raw = longint'($urandom);
      ry  = raw[skt_pkg::InW-1:0];
      case ($urandom_range(0, 9)) inside
        0: rx = lx;
        [1:3]: begin
          delta = longint'($urandom_range(1, 1 << $urandom_range(0, 16)));
          if ($urandom_range(0, 1) != 0) delta = -delta;
          shifted = longint'(lx) - delta;
          // Flip the offset if it would leave the coordinate range
          if (shifted < longint'(CoordMin) || shifted > longint'(CoordMax)) begin
            shifted = longint'(lx) + delta;
          end
          rx = shifted[skt_pkg::InW-1:0];
        end
        [4:5]: begin
          raw = longint'($urandom_range(0, 2097152)) - 1048576;
          lx  = raw[skt_pkg::InW-1:0];
          raw = longint'(lx) - longint'($urandom_range(0, 262144));
          rx  = raw[skt_pkg::InW-1:0];
          raw = longint'($urandom_range(0, 2097152)) - 1048576;
          ly  = raw[skt_pkg::InW-1:0];
          raw = longint'(ly) + longint'($urandom_range(0, 64)) - 32;
          ry  = raw[skt_pkg::InW-1:0];
        end
        9: begin
          lx = Corner[$urandom_range(0, 4)];
          ly = Corner[$urandom_range(0, 4)];
          rx = Corner[$urandom_range(0, 4)];
          ry = Corner[$urandom_range(0, 4)];
        end
        default: ;
      endcase
      send_point(make_point(lx, ly, rx, ry));
    end
    drain();
  endtask

  // Receiver: check every result transfer, then, while sink_idle is set, stall
  // ready for a random gap before accepting the next one.
  initial begin
    int unsigned hold;
    hold = 0;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_result(out_data_o);
        hold = sink_idle ? $urandom_range(0, 5) : 0;
      end
      @(negedge clk_i);
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    skt_pkg::in_t directed[$];
    logic [31:0]  seed_base;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    sb         = new();
    src_idle   = 1'b1;
    sink_idle  = 1'b1;
    n_settings = 1;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed keypoints at the reset baseline
    directed.push_back(make_point(0, 0, 0, 0));                          // zero disparity
    directed.push_back(make_point(8388607, 8388607, -8388608, 8388607));  // widest disparity
    directed.push_back(make_point(-8388608, -8388608, 8388607, -8388608));
    directed.push_back(make_point(1, 0, 0, 0));                          // saturate depth
    directed.push_back(make_point(0, 8388607, 1, 8388607));
    directed.push_back(make_point(-8388608, 8388607, -8388608, -8388608)); // zero, busy y
    directed.push_back(make_point(131072, 0, 0, 0));                     // depth tie
    directed.push_back(make_point(0, 0, 131072, 0));                     // mirrored tie
    directed.push_back(make_point(65536, 0, -65536, 0));                 // depth tie, x coordinates summing to zero
    directed.push_back(make_point(104858, -20972, 52429, -20972));        // typical point
    directed.push_back(make_point(1048576, -8388608, 0, -8388608));
    directed.push_back(make_point(-1, 8388607, 0, 8388607));
    directed.push_back(make_point(8388607, 0, 8388606, 0));
    directed.push_back(make_point(-8388608, 5, -8388607, -5));
    directed.push_back(make_point(4194304, 1, -4194304, 2));
    foreach (directed[k]) send_point(directed[k]);
    drain();

    // Baseline extremes and the reset value, then random settings, each with
    // its own idling mix so that some stretches run with no gaps at all
    run_phase(BaseMax, 0);
    run_phase('0, 1);
    run_phase({{(skt_pkg::BaseW - 1){1'b0}}, 1'b1}, 2);
    run_phase(skt_pkg::BaseReset, 3);
    repeat (4) begin
      seed_base = $urandom;
      run_phase(seed_base[skt_pkg::BaseW-1:0], $urandom_range(0, 3));
    end

    drain();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Covered %0d keypoints over %0d baseline settings: %0d zero disparity, %0d saturated.",
             sb.n_points, n_settings, sb.n_zero_disp, sb.n_saturated);
    $display("Mismatches: %0d, positions still outstanding: %0d.", sb.n_errors, sb.pending());
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("stereo_keypoint_triangulation_top_tb: PASS");
    end else begin
      $display("stereo_keypoint_triangulation_top_tb: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("stereo_keypoint_triangulation_top_tb: FAIL");
    $finish;
  end

endmodule
